### rtl/hc4_pkg.sv
// Types, constants and arithmetic helpers for the Hermite corrector pipeline
package hc4_pkg;

	localparam logic [47:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIM  = 48'h8000_0000_0000;
	// (2^48 + 2) / 3: exact floor division by three for operands below 2^47
	localparam logic [46:0] DIV3_MUL = 47'd93824992236886;

	// Partial products of a signed 56 by 48 bit multiply, split into 28 by 24 bit pieces;
	// the first letter names the half of a, the second the half of b
	typedef struct packed {
		logic        neg;
		logic [51:0] ll;
		logic [51:0] hl;
		logic [51:0] lh;
		logic [51:0] hh;
	} mulp_t;

	// Partial products of the divide-by-twelve reciprocal multiply, 23 by 24 and 23 by 23 bit pieces
	typedef struct packed {
		logic        neg;
		logic [46:0] ll;
		logic [46:0] hl;
		logic [46:0] lh;
		logic [46:0] hh;
	} d12p_t;

	// Reciprocal divider state, one quotient bit per stage
	typedef struct packed {
		logic        over;
		logic [46:0] dt;
		logic [46:0] rem;
		logic [46:0] nl;
		logic [46:0] q;
	} dvs_t;

	// Per-item context that travels with the valid bit
	typedef struct packed {
		logic               hit;
		logic               last;
		logic [46:0]        dt;
		logic signed [48:0] da;
		logic signed [47:0] v0;
		logic signed [47:0] r0;
		logic signed [47:0] p1;
		logic signed [47:0] dv;
		logic signed [47:0] dr;
		logic signed [47:0] v1;
		logic signed [47:0] r1;
		logic signed [53:0] n2;
		logic signed [53:0] n3;
	} ctx_t;

	function automatic mulp_t mul_part(logic signed [55:0] a, logic signed [47:0] b);
		logic [55:0] ma;
		logic [47:0] mb;
		mulp_t       r;
		ma    = a[55] ? 56'(-a) : 56'(a);
		mb    = b[47] ? 48'(-b) : 48'(b);
		r.neg = a[55] ^ b[47];
		r.ll  = 52'(ma[27:0]) * 52'(mb[23:0]);
		r.hl  = 52'(ma[55:28]) * 52'(mb[23:0]);
		r.lh  = 52'(ma[27:0]) * 52'(mb[47:24]);
		r.hh  = 52'(ma[55:28]) * 52'(mb[47:24]);
		return r;
	endfunction

	// Sum partials, round half away from zero, shift and saturate
	function automatic logic signed [47:0] mul_fin(mulp_t p, int unsigned sh);
		logic [103:0] s;
		logic [103:0] q;
		logic [47:0]  lim;
		s   = 104'(p.ll) + (104'(p.hl) << 28) + (104'(p.lh) << 24) + (104'(p.hh) << 52)
			+ (104'(1) << (sh - 1));
		q   = s >> sh;
		lim = p.neg ? NEG_LIM : POS_MAX;
		if (q > 104'(lim)) begin
			q = 104'(lim);
		end
		return p.neg ? -q[47:0] : q[47:0];
	endfunction

	function automatic d12p_t d12_part(logic signed [47:0] x);
		logic [47:0] m;
		logic [47:0] xs;
		logic [45:0] y;
		d12p_t       r;
		m     = x[47] ? 48'(-x) : 48'(x);
		xs    = m + 48'd6;
		y     = xs[47:2];
		r.neg = x[47];
		r.ll  = 47'(y[22:0]) * 47'(DIV3_MUL[23:0]);
		r.hl  = 47'(y[45:23]) * 47'(DIV3_MUL[23:0]);
		r.lh  = 47'(y[22:0]) * 47'(DIV3_MUL[46:24]);
		r.hh  = 47'(y[45:23]) * 47'(DIV3_MUL[46:24]);
		return r;
	endfunction

	function automatic logic signed [47:0] d12_fin(d12p_t p);
		logic [93:0] s;
		logic [45:0] q;
		s = 94'(p.ll) + (94'(p.hl) << 23) + (94'(p.lh) << 24) + (94'(p.hh) << 47);
		q = s[93:48];
		return p.neg ? -48'(q) : 48'(q);
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [49:0] x);
		logic signed [47:0] r;
		r = x[47:0];
		if (x > $signed({2'b00, POS_MAX})) begin
			r = POS_MAX;
		end else if (x < $signed({2'b11, NEG_LIM})) begin
			r = NEG_LIM;
		end
		return r;
	endfunction

endpackage

### rtl/hermite4_corrector.sv
// Top level: fully pipelined time-symmetric fourth-order Hermite corrector
//
// Channel   Direction  Transfer condition      Payload
// command   in         start & !busy           now_tick .. pos_old, last_item
// result    out        strobe (one cycle)      corrected, snap, crackle, vel_new,
//                                              pos_new, last_out
// config    in         base_step_we            base_step_wdata
//
// An item enters on every cycle; busy stays low because nothing downstream can stall.
// The pipeline depth is set by the 47-stage restoring divider that forms 1/dt,
// followed by the three chained multiplies of the crackle term.
// Reset clears the valid bits and loads base_step with 2^20; the data path holds no
// reset. The receiver cannot hold off a result: each one shows for exactly one cycle.
module hermite4_corrector import hc4_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [23:0]        now_tick,
	input  logic [23:0]        last_tick,
	input  logic [16:0]        step_ticks,
	input  logic signed [47:0] acc_old,
	input  logic signed [47:0] acc_new,
	input  logic signed [47:0] jerk_old,
	input  logic signed [47:0] jerk_new,
	input  logic signed [47:0] vel_old,
	input  logic signed [47:0] pos_old,
	input  logic               last_item,
	input  logic               base_step_we,
	input  logic [31:0]        base_step_wdata,
	output logic               strobe,
	output logic               corrected,
	output logic signed [47:0] snap,
	output logic signed [47:0] crackle,
	output logic signed [47:0] vel_new,
	output logic signed [47:0] pos_new,
	output logic               last_out
);

	localparam int unsigned SH      = FRAC_BITS;
	localparam int unsigned SH_HALF = FRAC_BITS + 1;
	localparam int          NSTG    = 55;

	// Never stalls: every cycle is a transfer opportunity
	assign busy = 1'b0;

	logic [31:0] base_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q <= 32'd1048576;
		end else if (base_step_we) begin
			base_step_q <= base_step_wdata;
		end
	end

	// Valid bits travel alongside the context
	logic vld_s [1:NSTG];
	ctx_t ctx_s [1:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else begin
			vld_s[1] <= start & ~busy;
		end
	end

	for (genvar k = 2; k <= NSTG; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Stage 1: form dt, decide whether this step has ended
	logic signed [24:0] tick_diff;
	logic [48:0]        dt_prod;
	logic [46:0]        dt_c;
	ctx_t               ctx1_c;
	logic signed [47:0] a0_s1, a1_s1, j0_s1, j1_s1;

	always_comb begin
		tick_diff   = $signed({1'b0, now_tick}) - $signed({1'b0, last_tick});
		dt_prod     = 49'(base_step_q) * 49'(step_ticks);
		dt_c        = (dt_prod > 49'(POS_MAX)) ? POS_MAX[46:0] : dt_prod[46:0];
		ctx1_c      = '0;
		ctx1_c.hit  = (tick_diff == $signed({8'd0, step_ticks})) && (dt_c != '0);
		ctx1_c.last = last_item;
		ctx1_c.dt   = dt_c;
		ctx1_c.da   = 49'(acc_old) - 49'(acc_new);
		ctx1_c.v0   = vel_old;
		ctx1_c.r0   = pos_old;
	end

	always_ff @(posedge clk) begin
		ctx_s[1] <= ctx1_c;
		a0_s1    <= acc_old;
		a1_s1    <= acc_new;
		j0_s1    <= jerk_old;
		j1_s1    <= jerk_new;
	end

	// Stages 2-3: first round of dt products
	logic signed [47:0] dt1_c;
	mulp_t              p1_p_s2, p2_p_s2, p5_p_s2, q1_p_s2, q2_p_s2;

	assign dt1_c = $signed({1'b0, ctx_s[1].dt});

	always_ff @(posedge clk) begin
		ctx_s[2] <= ctx_s[1];
		p1_p_s2  <= mul_part(56'(a0_s1) + 56'(a1_s1), dt1_c);
		p2_p_s2  <= mul_part(56'(j1_s1) - 56'(j0_s1), dt1_c);
		p5_p_s2  <= mul_part(56'(a1_s1) - 56'(a0_s1), dt1_c);
		q1_p_s2  <= mul_part((56'(j0_s1) <<< 2) + (56'(j1_s1) <<< 1), dt1_c);
		q2_p_s2  <= mul_part(56'(j0_s1) + 56'(j1_s1), dt1_c);
	end

	ctx_t               ctx3_c;
	logic signed [47:0] p2_s3, p5_s3, q1_s3, q2_s3;

	always_comb begin
		ctx3_c    = ctx_s[2];
		ctx3_c.p1 = mul_fin(p1_p_s2, SH_HALF);
	end

	always_ff @(posedge clk) begin
		ctx_s[3] <= ctx3_c;
		p2_s3    <= mul_fin(p2_p_s2, SH);
		p5_s3    <= mul_fin(p5_p_s2, SH);
		q1_s3    <= mul_fin(q1_p_s2, SH);
		q2_s3    <= mul_fin(q2_p_s2, SH);
	end

	// Stages 4-5: Hermite numerators, second dt products for the twelfth terms
	logic signed [53:0] da54_c;
	logic signed [47:0] dt3_c;
	ctx_t               ctx4_c;
	mulp_t              p3_p_s4, p6_p_s4;

	assign da54_c = 54'(ctx_s[3].da);
	assign dt3_c  = $signed({1'b0, ctx_s[3].dt});

	always_comb begin
		ctx4_c    = ctx_s[3];
		ctx4_c.n2 = -(da54_c * 54'sd6) - 54'(q1_s3);
		ctx4_c.n3 = (da54_c * 54'sd12) + (54'(q2_s3) * 54'sd6);
	end

	always_ff @(posedge clk) begin
		ctx_s[4] <= ctx4_c;
		p3_p_s4  <= mul_part(56'(p2_s3), dt3_c);
		p6_p_s4  <= mul_part(56'(p5_s3), dt3_c);
	end

	logic signed [47:0] p3_s5, p6_s5;

	always_ff @(posedge clk) begin
		ctx_s[5] <= ctx_s[4];
		p3_s5    <= mul_fin(p3_p_s4, SH);
		p6_s5    <= mul_fin(p6_p_s4, SH);
	end

	// Stages 6-7: divide by twelve through a reciprocal multiply
	d12p_t d3_p_s6, d6_p_s6;
	ctx_t  ctx7_c;

	always_ff @(posedge clk) begin
		ctx_s[6] <= ctx_s[5];
		d3_p_s6  <= d12_part(p3_s5);
		d6_p_s6  <= d12_part(p6_s5);
	end

	always_comb begin
		ctx7_c    = ctx_s[6];
		ctx7_c.dv = d12_fin(d3_p_s6);
		ctx7_c.dr = d12_fin(d6_p_s6);
	end

	always_ff @(posedge clk) begin
		ctx_s[7] <= ctx7_c;
	end

	// Stage 8: corrected velocity
	ctx_t ctx8_c;

	always_comb begin
		ctx8_c    = ctx_s[7];
		ctx8_c.v1 = sat48(50'(ctx_s[7].v0) + 50'(ctx_s[7].p1) - 50'(ctx_s[7].dv));
	end

	always_ff @(posedge clk) begin
		ctx_s[8] <= ctx8_c;
	end

	// Stages 9-11: position from the averaged velocity
	mulp_t p4_p_s9;

	always_ff @(posedge clk) begin
		ctx_s[9] <= ctx_s[8];
		p4_p_s9  <= mul_part(56'(ctx_s[8].v0) + 56'(ctx_s[8].v1),
			$signed({1'b0, ctx_s[8].dt}));
	end

	logic signed [47:0] p4_s10;
	ctx_t               ctx11_c;

	always_ff @(posedge clk) begin
		ctx_s[10] <= ctx_s[9];
		p4_s10    <= mul_fin(p4_p_s9, SH_HALF);
	end

	always_comb begin
		ctx11_c    = ctx_s[10];
		ctx11_c.r1 = sat48(50'(ctx_s[10].r0) + 50'(p4_s10) - 50'(ctx_s[10].dr));
	end

	always_ff @(posedge clk) begin
		ctx_s[11] <= ctx11_c;
	end

	// Hold the context while the reciprocal settles
	for (genvar k = 12; k <= NSTG; k++) begin : g_ctx
		always_ff @(posedge clk) begin
			ctx_s[k] <= ctx_s[k-1];
		end
	end

	// Reciprocal: round(2^(2F) / dt); quotient bits above 46 saturate
	dvs_t         div_s [2:49];
	logic [46:0]  dvsr_c;
	logic [127:0] div_num;
	logic [80:0]  num_hi;
	logic         over_c;

	always_comb begin
		dvsr_c  = (ctx_s[1].dt == '0) ? 47'd1 : ctx_s[1].dt;
		div_num = (128'd1 << (2 * FRAC_BITS)) + 128'(dvsr_c >> 1);
		num_hi  = div_num[127:47];
		over_c  = num_hi >= 81'(dvsr_c);
	end

	always_ff @(posedge clk) begin
		div_s[2].over <= over_c;
		div_s[2].dt   <= dvsr_c;
		div_s[2].rem  <= over_c ? '0 : num_hi[46:0];
		div_s[2].nl   <= div_num[46:0];
		div_s[2].q    <= '0;
	end

	for (genvar k = 3; k <= 49; k++) begin : g_div
		localparam int BI = 49 - k;
		logic [47:0] trial;
		logic        take;
		dvs_t        nxt;

		always_comb begin
			trial     = {div_s[k-1].rem, div_s[k-1].nl[BI]};
			take      = trial >= {1'b0, div_s[k-1].dt};
			nxt       = div_s[k-1];
			nxt.rem   = take ? 47'(trial - {1'b0, div_s[k-1].dt}) : trial[46:0];
			nxt.q[BI] = take;
		end

		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end
	end

	logic signed [47:0] inv_c;

	assign inv_c = div_s[49].over ? $signed(POS_MAX) : $signed({1'b0, div_s[49].q});

	// Stages 50-55: scale the numerators by 1/dt two and three times
	mulp_t              sn_p_s50, cr_p_s50;
	logic signed [47:0] inv_s50;

	always_ff @(posedge clk) begin
		sn_p_s50 <= mul_part(56'(ctx_s[49].n2), inv_c);
		cr_p_s50 <= mul_part(56'(ctx_s[49].n3), inv_c);
		inv_s50  <= inv_c;
	end

	logic signed [47:0] sn_s51, cr_s51, inv_s51;

	always_ff @(posedge clk) begin
		sn_s51  <= mul_fin(sn_p_s50, SH);
		cr_s51  <= mul_fin(cr_p_s50, SH);
		inv_s51 <= inv_s50;
	end

	mulp_t              sn_p_s52, cr_p_s52;
	logic signed [47:0] inv_s52;

	always_ff @(posedge clk) begin
		sn_p_s52 <= mul_part(56'(sn_s51), inv_s51);
		cr_p_s52 <= mul_part(56'(cr_s51), inv_s51);
		inv_s52  <= inv_s51;
	end

	logic signed [47:0] sn_s53, cr_s53, inv_s53;

	always_ff @(posedge clk) begin
		sn_s53  <= mul_fin(sn_p_s52, SH);
		cr_s53  <= mul_fin(cr_p_s52, SH);
		inv_s53 <= inv_s52;
	end

	mulp_t              cr_p_s54;
	logic signed [47:0] sn_s54;

	always_ff @(posedge clk) begin
		cr_p_s54 <= mul_part(56'(cr_s53), inv_s53);
		sn_s54   <= sn_s53;
	end

	logic signed [47:0] sn_s55, cr_s55;

	always_ff @(posedge clk) begin
		cr_s55 <= mul_fin(cr_p_s54, SH);
		sn_s55 <= sn_s54;
	end

	// Output register: pass old values through and zero the derivatives on a miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe    <= 1'b0;
			corrected <= 1'b0;
		end else begin
			strobe    <= vld_s[NSTG];
			corrected <= vld_s[NSTG] & ctx_s[NSTG].hit;
		end
	end

	always_ff @(posedge clk) begin
		snap     <= ctx_s[NSTG].hit ? sn_s55 : '0;
		crackle  <= ctx_s[NSTG].hit ? cr_s55 : '0;
		vel_new  <= ctx_s[NSTG].hit ? ctx_s[NSTG].v1 : ctx_s[NSTG].v0;
		pos_new  <= ctx_s[NSTG].hit ? ctx_s[NSTG].r1 : ctx_s[NSTG].r0;
		last_out <= ctx_s[NSTG].last;
	end

	a_corr_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		corrected |-> strobe)
		else $error("corrected raised without a result transfer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !corrected) |-> (snap == '0 && crackle == '0))
		else $error("derivatives not zero on an uncorrected result");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[49] |-> (div_s[49].rem < div_s[49].dt))
		else $error("reciprocal remainder not below divisor");

	a_hit_dt: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && ctx_s[1].hit) |-> (ctx_s[1].dt != '0))
		else $error("correction selected with zero dt");

endmodule
